>>> rtl/core/tcf_pkg.sv
// Constants, types and the CORDIC arctangent table for the tilt complementary filter.
package tcf_pkg;

   localparam int CORDIC_STEPS_DEF    = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 16;
   localparam int STEP_CAP            = 24;

   localparam logic [15:0] ALPHA_RST   = 16'd64225;
   localparam logic [23:0] SCALE_RST   = 24'd1024000;
   localparam logic [31:0] DT_FIRST    = 32'd1000;
   localparam logic [19:0] US_PER_S    = 20'd1000000;
   localparam logic [19:0] US_HALF     = 20'd500000;
   localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
   localparam logic [63:0] DEG_PER_RAD_Q32 = 64'd246083499208;
   localparam logic [27:0] RATE_MAX    = 28'd134217727;
   localparam int          FIELD26_MAX = 33554431;

   localparam logic REG_BLEND_ALPHA = 1'b0;
   localparam logic REG_GYRO_SCALE  = 1'b1;

   typedef logic signed [41:0] atan_tab_type [STEP_CAP];

   // atan(2^-i) in 2^-32 degree, series evaluated at elaboration
   function automatic atan_tab_type build_atan_tab();
      atan_tab_type t;
      logic [63:0]  p;
      logic [63:0]  sum;
      logic [63:0]  term;
      int           k;
      t[0] = 42'sd45 <<< 32;
      for (int i = 1; i < STEP_CAP; i++) begin
         p   = (DEG_PER_RAD_Q32 << 24) >> i;
         sum = 64'd0;
         k   = 0;
         for (int n = 0; n < 64; n++) begin
            if (p != 64'd0) begin
               term = p / 64'(2 * k + 1);
               if (k[0]) begin
                  sum = sum - term;
               end else begin
                  sum = sum + term;
               end
               p = p >> (2 * i);
               k = k + 1;
            end
         end
         t[i] = 42'((sum + 64'd8388608) >> 24);
      end
      return t;
   endfunction

   localparam atan_tab_type ATAN_TAB = build_atan_tab();

endpackage

>>> rtl/core/tilt_complementary_filter.sv
// Tilt complementary filter: accel CORDIC tilt, gyro scaling and blended roll/pitch.
// One word in gives one word out. Each word runs two CORDIC vectoring passes on one
// shared shift-add unit, one iteration per cycle, then per axis a bit-serial
// restoring divide by 10^6. The result sits in an output register, so the next word
// is accepted while it waits. The user must write configuration only while idle;
// the block itself does not enforce this.
module tilt_complementary_filter #(
   parameter int CORDIC_STEPS    = tcf_pkg::CORDIC_STEPS_DEF,
   parameter int ANGLE_FRAC_BITS = tcf_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, timestamp_us
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // roll_angle, pitch_angle, roll_dps, pitch_dps, 4 zero bits
   output logic [111:0] rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [23:0]  csr_wdata
);

   localparam int RS      = 24 - ANGLE_FRAC_BITS;
   localparam int ZS      = 32 - ANGLE_FRAC_BITS;
   localparam int LIM_RAW = 360 << ANGLE_FRAC_BITS;
   localparam int LIM     = (LIM_RAW > tcf_pkg::FIELD26_MAX) ? tcf_pkg::FIELD26_MAX : LIM_RAW;

   typedef enum logic [3:0] {
      S_IDLE, S_RATE, S_CLOAD, S_CITER, S_CEND, S_HYP,
      S_INC, S_DIV, S_MIX, S_MUL, S_SUM, S_FIN, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic pass_ff, pass_in;
   logic signed [15:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in, gx_ff, gx_in, gy_ff, gy_in;
   logic [31:0] dt_ff, dt_in, prev_ff, prev_in;
   logic seen_ff, seen_in;
   logic [15:0] alpha_ff, alpha_in;
   logic [23:0] scale_ff, scale_in;
   logic signed [40:0] gp_ff, gp_in;
   logic signed [27:0] rrate_ff, rrate_in, prate_ff, prate_in;
   logic signed [35:0] x_ff, x_in, y_ff, y_in;
   logic signed [41:0] z_ff, z_in;
   logic zero_ff, zero_in;
   logic [65:0] hacc_ff, hacc_in;
   logic signed [31:0] racc_ff, racc_in, pacc_ff, pacc_in;
   logic [59:0] num_ff, num_in;
   logic [19:0] rem_ff, rem_in;
   logic neg_ff, neg_in;
   logic signed [42:0] diff_ff, diff_in;
   logic signed [59:0] prod_ff, prod_in;
   logic signed [60:0] mix_ff, mix_in;
   logic signed [25:0] rest_ff, rest_in, pest_ff, pest_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [25:0] oroll_ff, oroll_in, opitch_ff, opitch_in;
   logic signed [27:0] orr_ff, orr_in, opr_ff, opr_in;

   always_comb begin
      logic signed [15:0] gsel;
      logic [40:0] gmag, grnd;
      logic [27:0] gsat;
      logic signed [27:0] grate;
      logic signed [35:0] xs, ys, cx, cy;
      logic signed [41:0] at;
      logic [41:0] zmag, zrnd;
      logic signed [31:0] zacc;
      logic [65:0] hyp_w;
      logic signed [27:0] rsel;
      logic [26:0] rmag;
      logic [20:0] t;
      logic ge;
      logic signed [25:0] esel;
      logic signed [31:0] asel;
      logic signed [42:0] qs, pred;
      logic [60:0] mmag, mrnd;
      logic [25:0] msat;
      logic signed [25:0] enew;

      state_in = state_ff;  cnt_in = cnt_ff;  pass_in = pass_ff;
      ax_in = ax_ff;  ay_in = ay_ff;  az_in = az_ff;  gx_in = gx_ff;  gy_in = gy_ff;
      dt_in = dt_ff;  prev_in = prev_ff;  seen_in = seen_ff;
      alpha_in = alpha_ff;  scale_in = scale_ff;  gp_in = gp_ff;
      rrate_in = rrate_ff;  prate_in = prate_ff;
      x_in = x_ff;  y_in = y_ff;  z_in = z_ff;  zero_in = zero_ff;  hacc_in = hacc_ff;
      racc_in = racc_ff;  pacc_in = pacc_ff;  num_in = num_ff;  rem_in = rem_ff;
      neg_in = neg_ff;  diff_in = diff_ff;  prod_in = prod_ff;  mix_in = mix_ff;
      rest_in = rest_ff;  pest_in = pest_ff;
      oroll_in = oroll_ff;  opitch_in = opitch_ff;  orr_in = orr_ff;  opr_in = opr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      if (csr_we) begin
         case (csr_index)
            tcf_pkg::REG_BLEND_ALPHA: alpha_in = csr_wdata[15:0];
            tcf_pkg::REG_GYRO_SCALE:  scale_in = csr_wdata;
            default: ;
         endcase
      end

      // rate rounding from the registered gyro product
      gmag  = gp_ff[40] ? 41'(-gp_ff) : 41'(gp_ff);
      grnd  = (gmag + (41'd1 << (RS - 1))) >> RS;
      gsat  = (grnd > 41'(tcf_pkg::RATE_MAX)) ? tcf_pkg::RATE_MAX : grnd[27:0];
      grate = gp_ff[40] ? -$signed(gsat) : $signed(gsat);
      gsel  = (cnt_ff[0]) ? gy_ff : gx_ff;

      xs = x_ff >>> cnt_ff[4:0];
      ys = y_ff >>> cnt_ff[4:0];
      at = tcf_pkg::ATAN_TAB[cnt_ff[4:0]];
      zmag = z_ff[41] ? 42'(-z_ff) : 42'(z_ff);
      zrnd = (zmag + (42'd1 << (ZS - 1))) >> ZS;
      zacc = z_ff[41] ? -$signed(zrnd[31:0]) : $signed(zrnd[31:0]);
      hyp_w = (hacc_ff + (66'd1 << 29)) >> 30;

      if (pass_ff) begin
         cx = $signed(hyp_w[35:0]);
         cy = -$signed({{4{ax_ff[15]}}, ax_ff, 16'h0});
      end else begin
         cx = $signed({{4{az_ff[15]}}, az_ff, 16'h0});
         cy = $signed({{4{ay_ff[15]}}, ay_ff, 16'h0});
      end

      rsel = pass_ff ? prate_ff : rrate_ff;
      rmag = rsel[27] ? 27'(-rsel) : rsel[26:0];
      t    = {rem_ff, num_ff[59]};
      ge   = (t >= 21'(tcf_pkg::US_PER_S));

      esel = pass_ff ? pest_ff : rest_ff;
      asel = pass_ff ? pacc_ff : racc_ff;
      qs   = $signed({2'b00, num_ff[40:0]});
      pred = 43'(esel) + (neg_ff ? -qs : qs);

      mmag = mix_ff[60] ? 61'(-mix_ff) : 61'(mix_ff);
      mrnd = (mmag + 61'd32768) >> 16;
      msat = (mrnd > 61'(LIM)) ? 26'(LIM) : mrnd[25:0];
      enew = mix_ff[60] ? -$signed(msat) : $signed(msat);

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ax_in = req_tdata[15:0];
               ay_in = req_tdata[31:16];
               az_in = req_tdata[47:32];
               gx_in = req_tdata[63:48];
               gy_in = req_tdata[79:64];
               dt_in = seen_ff ? (req_tdata[111:80] - prev_ff) : tcf_pkg::DT_FIRST;
               prev_in  = req_tdata[111:80];
               seen_in  = 1'b1;
               cnt_in   = 6'd0;
               pass_in  = 1'b0;
               state_in = S_RATE;
            end
         end
         S_RATE: begin
            gp_in = gsel * $signed({1'b0, scale_ff});
            if (cnt_ff[1:0] == 2'd1) begin
               rrate_in = grate;
            end
            if (cnt_ff[1:0] == 2'd2) begin
               prate_in = grate;
               state_in = S_CLOAD;
            end
            cnt_in = cnt_ff + 6'd1;
         end
         S_CLOAD: begin
            cnt_in  = 6'd0;
            zero_in = 1'b0;
            if (cx == 36'sd0 && cy == 36'sd0) begin
               x_in = '0;  y_in = '0;  z_in = '0;  zero_in = 1'b1;
            end else if (cx < 0) begin
               if (cy >= 0) begin
                  x_in = cy;  y_in = -cx;  z_in = 42'sd90 <<< 32;
               end else begin
                  x_in = -cy;  y_in = cx;  z_in = -(42'sd90 <<< 32);
               end
            end else begin
               x_in = cx;  y_in = cy;  z_in = '0;
            end
            state_in = S_CITER;
         end
         S_CITER: begin
            if (!zero_ff) begin
               if (y_ff > 0) begin
                  x_in = x_ff + ys;  y_in = y_ff - xs;  z_in = z_ff + at;
               end else begin
                  x_in = x_ff - ys;  y_in = y_ff + xs;  z_in = z_ff - at;
               end
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[4:0] == 5'(CORDIC_STEPS - 1)) begin
               state_in = S_CEND;
            end
         end
         S_CEND: begin
            cnt_in = 6'd0;
            if (pass_ff) begin
               pacc_in  = zacc;
               pass_in  = 1'b0;
               state_in = S_INC;
            end else begin
               racc_in  = zacc;
               state_in = S_HYP;
            end
         end
         S_HYP: begin
            // magnitude times 1/K in two 18-bit halves
            if (cnt_ff[0]) begin
               hacc_in  = hacc_ff + (66'(x_ff[35:18] * tcf_pkg::INV_GAIN_Q30) << 18);
               pass_in  = 1'b1;
               state_in = S_CLOAD;
            end else begin
               hacc_in = 66'(x_ff[17:0] * tcf_pkg::INV_GAIN_Q30);
            end
            cnt_in = cnt_ff + 6'd1;
         end
         S_INC: begin
            neg_in   = rsel[27];
            num_in   = 60'(rmag * dt_ff) + 60'(tcf_pkg::US_HALF);
            rem_in   = '0;
            cnt_in   = 6'd0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = ge ? 20'(t - 21'(tcf_pkg::US_PER_S)) : t[19:0];
            num_in = {num_ff[58:0], ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd59) begin
               state_in = S_MIX;
            end
         end
         S_MIX: begin
            diff_in  = pred - 43'(asel);
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = 60'(diff_ff * $signed({1'b0, alpha_ff}));
            state_in = S_SUM;
         end
         S_SUM: begin
            mix_in   = 61'(prod_ff) + (61'(asel) <<< 16);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (pass_ff) begin
               pest_in  = enew;
               state_in = S_OUT;
            end else begin
               rest_in  = enew;
               pass_in  = 1'b1;
               state_in = S_INC;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               oroll_in     = rest_ff;
               opitch_in    = pest_ff;
               orr_in       = rrate_ff;
               opr_in       = prate_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pass_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         prev_ff      <= '0;
         rest_ff      <= '0;
         pest_ff      <= '0;
         alpha_ff     <= tcf_pkg::ALPHA_RST;
         scale_ff     <= tcf_pkg::SCALE_RST;
         rsp_valid_ff <= 1'b0;
         zero_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pass_ff      <= pass_in;
         seen_ff      <= seen_in;
         prev_ff      <= prev_in;
         rest_ff      <= rest_in;
         pest_ff      <= pest_in;
         alpha_ff     <= alpha_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
         zero_ff      <= zero_in;
      end
      ax_ff <= ax_in;  ay_ff <= ay_in;  az_ff <= az_in;  gx_ff <= gx_in;  gy_ff <= gy_in;
      dt_ff <= dt_in;  gp_ff <= gp_in;  rrate_ff <= rrate_in;  prate_ff <= prate_in;
      x_ff <= x_in;  y_ff <= y_in;  z_ff <= z_in;  hacc_ff <= hacc_in;
      racc_ff <= racc_in;  pacc_ff <= pacc_in;  num_ff <= num_in;  rem_ff <= rem_in;
      neg_ff <= neg_in;  diff_ff <= diff_in;  prod_ff <= prod_in;  mix_ff <= mix_in;
      oroll_ff <= oroll_in;  opitch_ff <= opitch_in;  orr_ff <= orr_in;  opr_ff <= opr_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, opr_ff, orr_ff, opitch_ff, oroll_ff};

endmodule
